// File: hdl/psl_pkg.sv
`default_nettype none
package psl_pkg;

  localparam int COUNT_WIDTH      = 16;
  localparam int THRESH_FRAC_BITS = 32;
  localparam int THRESH_W         = THRESH_FRAC_BITS + 1;
  localparam int GEN_BITS         = 26;
  localparam int DRAW_W           = 32;
  localparam int REQ_W            = 2;
  localparam int QUEUE_DEPTH      = 2;
  localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

  localparam logic [GEN_BITS-1:0] SEED_RESET = GEN_BITS'(13421773);

  typedef enum logic [REQ_W-1:0] {
    REQ_UNIFORM = 2'd0,
    REQ_POISSON = 2'd1,
    REQ_RESEED  = 2'd2,
    REQ_UNUSED  = 2'd3
  } req_code_t;

  typedef enum logic [2:0] {
    CMD_UNIFORM,
    CMD_POISSON,
    CMD_RESEED,
    CMD_REJECT,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                   kind;
    logic [THRESH_FRAC_BITS-1:0] thresh;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEED,
    ST_GEN,
    ST_MUL
  } state_t;

endpackage
`default_nettype wire

// File: hdl/psl_front.sv
`default_nettype none
module psl_front (
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [psl_pkg::REQ_W-1:0]     in_req_type,
  input  wire logic [psl_pkg::THRESH_W-1:0]  in_exp_neg_lambda,
  input  wire logic                          q_full,
  output logic                               q_push,
  output psl_pkg::cmd_t                      q_wdata
);
  import psl_pkg::*;

  logic thresh_bad;

  assign in_ready   = !q_full;
  assign q_push     = in_valid && !q_full;
  assign thresh_bad = (in_exp_neg_lambda == '0) || in_exp_neg_lambda[THRESH_FRAC_BITS];

  always_comb begin
    q_wdata.thresh = in_exp_neg_lambda[THRESH_FRAC_BITS-1:0];
    unique case (req_code_t'(in_req_type))
      REQ_UNIFORM: q_wdata.kind = CMD_UNIFORM;
      REQ_POISSON: q_wdata.kind = thresh_bad ? CMD_REJECT : CMD_POISSON;
      REQ_RESEED:  q_wdata.kind = CMD_RESEED;
      default:     q_wdata.kind = CMD_NOP;
    endcase
  end

endmodule
`default_nettype wire

// File: hdl/psl_cmdq.sv
`default_nettype none
module psl_cmdq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire psl_pkg::cmd_t wdata,
  output logic               full,
  input  wire logic          pop,
  output logic               not_empty,
  output psl_pkg::cmd_t      rdata
);
  import psl_pkg::*;

  // depth is a power of two, so pointers wrap on their own
  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign rdata     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

// File: hdl/psl_back.sv
`default_nettype none
module psl_back (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [psl_pkg::GEN_BITS-1:0]         cfg_wr_data,
  input  wire logic                                 q_not_empty,
  input  wire psl_pkg::cmd_t                        q_rdata,
  output logic                                      q_pop,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [psl_pkg::GEN_BITS-1:0]              out_uniform_value,
  output logic [psl_pkg::COUNT_WIDTH-1:0]           out_poisson_count,
  output logic                                      out_error_flag,
  output logic                                      out_saturated_flag,
  output logic [psl_pkg::DRAW_W-1:0]                out_draws_made
);
  import psl_pkg::*;

  localparam int MULT_W = 12;
  localparam logic [MULT_W-1:0] GEN_MULT = MULT_W'(3125);
  localparam logic [THRESH_W-1:0] ONE = THRESH_W'(1) << THRESH_FRAC_BITS;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  function automatic logic [GEN_BITS-1:0] gen_advance(input logic [GEN_BITS-1:0] y);
    logic [GEN_BITS+MULT_W-1:0] m;
    m = y * GEN_MULT;
    return m[GEN_BITS-1:0];
  endfunction

  state_t                  state_r, state_nxt;
  cmd_kind_t               kind_r, kind_nxt;
  logic [GEN_BITS-1:0]     seed_r, seed_nxt;
  logic [GEN_BITS-1:0]     gen_r, gen_nxt;
  logic                    pending_r, pending_nxt;
  logic [THRESH_W-1:0]     prod_r, prod_nxt;
  logic [THRESH_FRAC_BITS-1:0] thresh_r, thresh_nxt;
  logic [COUNT_WIDTH-1:0]  step_r, step_nxt;
  logic [DRAW_W-1:0]       draws_r, draws_nxt;
  logic                    out_valid_r, out_valid_nxt;

  logic [GEN_BITS-1:0]     uval_r, uval_nxt;
  logic [COUNT_WIDTH-1:0]  count_r, count_nxt;
  logic                    err_r, err_nxt;
  logic                    sat_r, sat_nxt;
  logic [DRAW_W-1:0]       dout_r, dout_nxt;
  logic                    out_load;

  logic                    slot_free;
  logic [GEN_BITS-1:0]     gen_adv;
  logic [THRESH_W+GEN_BITS-1:0] mul_full;
  logic [THRESH_W-1:0]     prod_scaled;
  logic                    below;
  logic [COUNT_WIDTH-1:0]  step_inc;
  logic                    step_sat;
  logic                    mul_stop;

  assign slot_free   = !out_valid_r || out_ready;
  assign q_pop       = (state_r == ST_IDLE) && q_not_empty && slot_free;
  assign gen_adv     = gen_advance(gen_r);
  assign mul_full    = prod_r * gen_r;
  assign prod_scaled = mul_full[THRESH_W+GEN_BITS-1:GEN_BITS];
  assign below       = prod_scaled <= {1'b0, thresh_r};
  assign step_inc    = step_r + 1'b1;
  assign step_sat    = (step_inc == COUNT_MAX);
  assign mul_stop    = below || step_sat;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_pop && (q_rdata.kind == CMD_UNIFORM || q_rdata.kind == CMD_POISSON)) begin
          state_nxt = pending_r ? ST_SEED : ST_GEN;
        end
      end
      ST_SEED: state_nxt = ST_GEN;
      ST_GEN:  state_nxt = (kind_r == CMD_POISSON) ? ST_MUL : ST_IDLE;
      ST_MUL:  state_nxt = mul_stop ? ST_IDLE : ST_GEN;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    kind_nxt    = kind_r;
    seed_nxt    = cfg_wr_en ? cfg_wr_data : seed_r;
    gen_nxt     = gen_r;
    pending_nxt = pending_r;
    prod_nxt    = prod_r;
    thresh_nxt  = thresh_r;
    step_nxt    = step_r;
    draws_nxt   = draws_r;
    out_load    = 1'b0;
    uval_nxt    = '0;
    count_nxt   = '0;
    err_nxt     = 1'b0;
    sat_nxt     = 1'b0;
    dout_nxt    = draws_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          kind_nxt = q_rdata.kind;
          case (q_rdata.kind)
            CMD_POISSON: begin
              prod_nxt   = ONE;
              step_nxt   = '0;
              thresh_nxt = q_rdata.thresh;
            end
            CMD_UNIFORM: ;
            CMD_RESEED: begin
              pending_nxt = 1'b1;
              out_load    = 1'b1;
            end
            CMD_REJECT: begin
              err_nxt  = 1'b1;
              out_load = 1'b1;
            end
            default: out_load = 1'b1;
          endcase
        end
      end
      ST_SEED: begin
        gen_nxt     = gen_advance(seed_r);
        pending_nxt = 1'b0;
      end
      ST_GEN: begin
        gen_nxt   = gen_adv;
        draws_nxt = draws_r + 1'b1;
        if (kind_r == CMD_UNIFORM) begin
          out_load = 1'b1;
          uval_nxt = gen_adv;
          dout_nxt = draws_nxt;
        end
      end
      ST_MUL: begin
        prod_nxt = prod_scaled;
        if (!below) begin
          step_nxt = step_inc;
        end
        if (mul_stop) begin
          out_load  = 1'b1;
          count_nxt = below ? step_r : step_inc;
          sat_nxt   = !below;
        end
      end
      default: ;
    endcase
    out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      kind_r      <= CMD_NOP;
      seed_r      <= SEED_RESET;
      gen_r       <= '0;
      pending_r   <= 1'b1;
      prod_r      <= '0;
      step_r      <= '0;
      draws_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kind_r      <= kind_nxt;
      seed_r      <= seed_nxt;
      gen_r       <= gen_nxt;
      pending_r   <= pending_nxt;
      prod_r      <= prod_nxt;
      step_r      <= step_nxt;
      draws_r     <= draws_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    thresh_r <= thresh_nxt;
    if (out_load) begin
      uval_r  <= uval_nxt;
      count_r <= count_nxt;
      err_r   <= err_nxt;
      sat_r   <= sat_nxt;
      dout_r  <= dout_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_uniform_value  = uval_r;
  assign out_poisson_count  = count_r;
  assign out_error_flag     = err_r;
  assign out_saturated_flag = sat_r;
  assign out_draws_made     = dout_r;

endmodule
`default_nettype wire

// File: hdl/poisson_sampler_lcg.sv
`default_nettype none
// Poisson sampler on a 26-bit multiplicative generator (y <- y*3125 mod 2^26).
// Requests enter a two-word command queue; the back end serves one at a time
// and holds its result in an output register, so new requests are taken while
// a result waits. Reseed, rejected-threshold and unused requests are finished
// in the idle state when popped; a uniform draw adds one generator step; a
// Poisson draw loops over one generator step and one 33x26 product multiply
// per step until the product falls to the threshold or the count saturates.
// The first draw after reset or a reseed adds a seed state to reload the
// generator from the seed register.
module poisson_sampler_lcg (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic [psl_pkg::GEN_BITS-1:0]      cfg_wr_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [psl_pkg::REQ_W-1:0]         in_req_type,
  input  wire logic [psl_pkg::THRESH_W-1:0]      in_exp_neg_lambda,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [psl_pkg::GEN_BITS-1:0]           out_uniform_value,
  output logic [psl_pkg::COUNT_WIDTH-1:0]        out_poisson_count,
  output logic                                   out_error_flag,
  output logic                                   out_saturated_flag,
  output logic [psl_pkg::DRAW_W-1:0]             out_draws_made
);
  import psl_pkg::*;

  logic q_full;
  logic q_push;
  cmd_t q_wdata;
  logic q_pop;
  logic q_not_empty;
  cmd_t q_rdata;

  psl_front u_front (
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_exp_neg_lambda (in_exp_neg_lambda),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_wdata           (q_wdata)
  );

  psl_cmdq u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rdata     (q_rdata)
  );

  psl_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .q_not_empty        (q_not_empty),
    .q_rdata            (q_rdata),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_uniform_value  (out_uniform_value),
    .out_poisson_count  (out_poisson_count),
    .out_error_flag     (out_error_flag),
    .out_saturated_flag (out_saturated_flag),
    .out_draws_made     (out_draws_made)
  );

endmodule
`default_nettype wire
